// ===== design/lfr_pkg.sv =====
// lfr_pkg: shared types and codes for the lru frame replacer
// no dependencies; used by the cells, the match encoder, the top level and the testbench
`timescale 1ns / 1ps

package lfr_pkg;

    localparam int FID_W = 6;
    localparam int CNT_W = 7;

    // operation codes of the kind field
    localparam logic [1:0] KIND_VICTIM = 2'd0;
    localparam logic [1:0] KIND_PIN    = 2'd1;
    localparam logic [1:0] KIND_UNPIN  = 2'd2;

    typedef struct packed {
        logic [1:0]       kind;
        logic [FID_W-1:0] frame_num;
    } lfr_in_t;

    typedef struct packed {
        logic             victim_found;
        logic [FID_W-1:0] victim_frame;
        logic [CNT_W-1:0] evictable_count;
    } lfr_out_t;

    // broadcast control from the top level to every cell
    typedef struct packed {
        logic             sample;     // capture match against fid
        logic [FID_W-1:0] fid;
        logic             shift_en;   // cells at or above shift_pos take upper neighbor
        logic [CNT_W-1:0] shift_pos;
        logic             ins_en;     // cell at ins_pos loads ins_fid
        logic [CNT_W-1:0] ins_pos;
        logic [FID_W-1:0] ins_fid;
    } lfr_ctrl_t;

endpackage

// ===== design/lfr_cell.sv =====
// lfr_cell: one list entry of the recency row (frame id, valid, match flag)
// depends on lfr_pkg
`timescale 1ns / 1ps

module lfr_cell
    import lfr_pkg::*;
#(
    parameter int IDX = 0
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  lfr_ctrl_t        ctrl,
    input  logic [FID_W-1:0] up_id,
    input  logic             up_valid,
    output logic [FID_W-1:0] id,
    output logic             valid,
    output logic             match
);

    localparam logic [CNT_W-1:0] MY_POS = CNT_W'(IDX);

    logic [FID_W-1:0] id_reg, id_next;
    logic             valid_reg, valid_next;
    logic             match_reg, match_next;

    // sample the match flag; shift down from upper neighbor, or load a newly unpinned frame
    always_comb begin
        id_next    = id_reg;
        valid_next = valid_reg;
        match_next = match_reg;
        if (ctrl.sample) begin
            match_next = valid_reg && (id_reg == ctrl.fid);
        end
        if (ctrl.shift_en && (MY_POS >= ctrl.shift_pos)) begin
            id_next    = up_id;
            valid_next = up_valid;
        end else if (ctrl.ins_en && (MY_POS == ctrl.ins_pos)) begin
            id_next    = ctrl.ins_fid;
            valid_next = 1'b1;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            match_reg <= match_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        id_reg <= id_next;
    end

    assign id    = id_reg;
    assign valid = valid_reg;
    assign match = match_reg;

endmodule

// ===== design/lfr_match_enc.sv =====
// lfr_match_enc: encodes the one-hot match row into a cell position
// depends on lfr_pkg
`timescale 1ns / 1ps

module lfr_match_enc
    import lfr_pkg::*;
#(
    parameter int CELLS = 64
) (
    input  logic [CELLS-1:0] match,
    output logic             any,
    output logic [CNT_W-1:0] pos
);

    localparam int IDX_W = (CELLS > 1) ? $clog2(CELLS) : 1;

    logic [IDX_W-1:0] enc;

    // or tree per position bit, valid since frames in the row are distinct
    always_comb begin
        enc = '0;
        for (int b = 0; b < IDX_W; b++) begin
            for (int i = 0; i < CELLS; i++) begin
                if (((i >> b) & 1) == 1) begin
                    enc[b] = enc[b] | match[i];
                end
            end
        end
    end

    assign any = |match;
    assign pos = CNT_W'(enc);

endmodule

// ===== design/lru_frame_replacer.sv =====
// lru_frame_replacer: recency-ordered list of evictable frames as a row of cells
// depends on lfr_pkg, lfr_cell, lfr_match_enc
// a result is registered in the output register once its item finishes; an item cannot finish
//   while a previous result still waits in the output register
// the cell row samples its match flags when an item is transferred and shifts or
//   inserts when it finishes; one item in flight, no new item taken before that
// an output register holds the result, so the next item is taken while it waits
// reset: synchronous, clears cell valid bits and the count; no clearing pass
`timescale 1ns / 1ps

module lru_frame_replacer
    import lfr_pkg::*;
#(
    parameter int NUM_FRAMES = 64
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  lfr_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output lfr_out_t m_data
);

    // only 64 distinct ids exist, so the row never needs more cells
    localparam int CELLS = (NUM_FRAMES < 64) ? NUM_FRAMES : 64;
    localparam logic [CNT_W-1:0] CELLS_CNT = CNT_W'(CELLS);
    localparam logic [CNT_W-1:0] ONE_CNT   = CNT_W'(1);

    logic             busy_reg, busy_next;
    lfr_in_t          item_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             m_valid_reg, m_valid_next;
    lfr_out_t         m_data_reg, m_data_next;

    lfr_ctrl_t        ctrl;
    logic [FID_W-1:0] cell_id [CELLS];
    logic [CELLS-1:0] cell_valid;
    logic [CELLS-1:0] cell_match;
    logic             any_match;
    logic [CNT_W-1:0] match_pos;

    logic in_xfer;
    logic finish;
    logic fid_ok;

    assign s_ready = !busy_reg;
    assign in_xfer = s_valid && s_ready;
    assign finish  = busy_reg && (!m_valid_reg || m_ready);
    assign fid_ok  = ({{(32 - FID_W){1'b0}}, item_reg.frame_num} < 32'(NUM_FRAMES));

    // row of cells, each takes its upper neighbor on a shift
    for (genvar i = 0; i < CELLS; i++) begin : g_cell
        logic [FID_W-1:0] up_id;
        logic             up_valid;
        if (i == CELLS - 1) begin : g_top
            assign up_id    = '0;
            assign up_valid = 1'b0;
        end else begin : g_mid
            assign up_id    = cell_id[i+1];
            assign up_valid = cell_valid[i+1];
        end
        lfr_cell #(
            .IDX(i)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (ctrl),
            .up_id    (up_id),
            .up_valid (up_valid),
            .id       (cell_id[i]),
            .valid    (cell_valid[i]),
            .match    (cell_match[i])
        );
    end

    lfr_match_enc #(
        .CELLS(CELLS)
    ) u_enc (
        .match (cell_match),
        .any   (any_match),
        .pos   (match_pos)
    );

    // operation decode: sample on transfer, shift or insert when the item finishes
    always_comb begin
        ctrl.sample    = in_xfer;
        ctrl.fid       = s_data.frame_num;
        ctrl.shift_en  = 1'b0;
        ctrl.shift_pos = '0;
        ctrl.ins_en    = 1'b0;
        ctrl.ins_pos   = count_reg;
        ctrl.ins_fid   = item_reg.frame_num;

        busy_next    = busy_reg;
        count_next   = count_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (in_xfer) begin
            busy_next = 1'b1;
        end

        if (finish) begin
            busy_next                  = 1'b0;
            m_valid_next               = 1'b1;
            m_data_next.victim_found   = 1'b0;
            m_data_next.victim_frame   = '0;
            case (item_reg.kind)
                KIND_VICTIM: begin
                    if (count_reg != '0) begin
                        m_data_next.victim_found = 1'b1;
                        m_data_next.victim_frame = cell_id[0];
                        ctrl.shift_en            = 1'b1;
                        count_next               = count_reg - ONE_CNT;
                    end
                end
                KIND_PIN: begin
                    if (fid_ok && any_match) begin
                        ctrl.shift_en  = 1'b1;
                        ctrl.shift_pos = match_pos;
                        count_next     = count_reg - ONE_CNT;
                    end
                end
                KIND_UNPIN: begin
                    if (fid_ok && !any_match && (count_reg < CELLS_CNT)) begin
                        ctrl.ins_en = 1'b1;
                        count_next  = count_reg + ONE_CNT;
                    end
                end
                default: begin
                end
            endcase
            m_data_next.evictable_count = count_next;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        if (in_xfer) begin
            item_reg <= s_data;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CELLS_CNT)
        else $error("count exceeds cell row");

    a_head_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != '0) == cell_valid[0])
        else $error("head cell valid disagrees with count");

    a_match_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(cell_match))
        else $error("frame listed in more than one cell");

    a_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        finish |=> (!busy_reg && m_valid_reg))
        else $error("finished item did not reach the output register");

endmodule

// ===== verif/lru_frame_replacer_tb.sv =====
// lru_frame_replacer_tb: self-checking testbench for the lru frame replacer
// depends on lfr_pkg and lru_frame_replacer; directed table, then random phases
// with sender idling and receiver stalls, checked against typed-in expectations and an in-bench predictor
`timescale 1ns / 1ps

module lru_frame_replacer_tb
    import lfr_pkg::*;
();

    localparam int NUM_FRAMES   = 64;
    localparam int RESET_CYCLES = 7;
    localparam int DRAIN_CYCLES = 10;
    localparam int STALL_LIMIT  = 2000;
    localparam int PHASE_ITEMS  = 85;

    // kind value with no operation behind it
    localparam logic [1:0] KIND_NONE = 2'd3;

    // one row of the directed table; has_exp marks a typed-in expectation
    typedef struct packed {
        logic [1:0]       kind;
        logic [FID_W-1:0] frame_num;
        logic             has_exp;
        logic             found;
        logic [FID_W-1:0] frame;
        logic [CNT_W-1:0] count;
    } dir_row_t;

    localparam int DIR_ROWS = 24;
    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        // empty list: victim misses, pin misses, unknown kind does nothing
        '{KIND_VICTIM, 6'd0,  1'b1, 1'b0, 6'd0,  7'd0},
        '{KIND_VICTIM, 6'd63, 1'b1, 1'b0, 6'd0,  7'd0},
        '{KIND_PIN,    6'd0,  1'b1, 1'b0, 6'd0,  7'd0},
        '{KIND_PIN,    6'd63, 1'b1, 1'b0, 6'd0,  7'd0},
        '{KIND_NONE,   6'd63, 1'b1, 1'b0, 6'd0,  7'd0},
        // fill a few, duplicate unpin keeps its place
        '{KIND_UNPIN,  6'd63, 1'b1, 1'b0, 6'd0,  7'd1},
        '{KIND_UNPIN,  6'd0,  1'b1, 1'b0, 6'd0,  7'd2},
        '{KIND_UNPIN,  6'd63, 1'b1, 1'b0, 6'd0,  7'd2},
        '{KIND_UNPIN,  6'd42, 1'b1, 1'b0, 6'd0,  7'd3},
        '{KIND_NONE,   6'd21, 1'b1, 1'b0, 6'd0,  7'd3},
        '{KIND_VICTIM, 6'd0,  1'b1, 1'b1, 6'd63, 7'd2},
        '{KIND_UNPIN,  6'd63, 1'b1, 1'b0, 6'd0,  7'd3},
        // pin from the middle, then pin of a frame no longer listed
        '{KIND_PIN,    6'd42, 1'b1, 1'b0, 6'd0,  7'd2},
        '{KIND_PIN,    6'd42, 1'b1, 1'b0, 6'd0,  7'd2},
        '{KIND_VICTIM, 6'd0,  1'b1, 1'b1, 6'd0,  7'd1},
        '{KIND_VICTIM, 6'd0,  1'b1, 1'b1, 6'd63, 7'd0},
        '{KIND_VICTIM, 6'd0,  1'b1, 1'b0, 6'd0,  7'd0},
        // the rest goes through the predictor
        '{KIND_UNPIN,  6'd21, 1'b0, 1'b0, 6'd0,  7'd0},
        '{KIND_UNPIN,  6'd42, 1'b0, 1'b0, 6'd0,  7'd0},
        '{KIND_UNPIN,  6'd7,  1'b0, 1'b0, 6'd0,  7'd0},
        '{KIND_PIN,    6'd21, 1'b0, 1'b0, 6'd0,  7'd0},
        '{KIND_UNPIN,  6'd21, 1'b0, 1'b0, 6'd0,  7'd0},
        '{KIND_VICTIM, 6'd0,  1'b0, 1'b0, 6'd0,  7'd0},
        '{KIND_PIN,    6'd7,  1'b0, 1'b0, 6'd0,  7'd0}
    };

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    lfr_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    lfr_out_t m_data;

    // typed-in expectation travels with the item it belongs to
    logic     item_has_exp = 1'b0;
    lfr_out_t item_exp     = '0;

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int sent_cnt     = 0;
    int results_seen = 0;
    int mismatches   = 0;
    int idle_cycles  = 0;

    // predictor state: listed frames, least recent first
    logic [FID_W-1:0] lru_list [$];
    bit               listed [NUM_FRAMES];
    lfr_out_t         pending_results [$];
    lfr_out_t         predicted_res;
    lfr_out_t         oldest_res;

    lru_frame_replacer #(
        .NUM_FRAMES(NUM_FRAMES)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #5 aclk = ~aclk;

    // one operation on the predicted list, returns the expected result
    function automatic lfr_out_t predict_replacement(lfr_in_t item);
        lfr_out_t res;
        bit       hit;
        res = '0;
        hit = 1'b0;
        case (item.kind)
            KIND_VICTIM: begin
                if (lru_list.size() > 0) begin
                    res.victim_found = 1'b1;
                    res.victim_frame = lru_list[0];
                    listed[lru_list[0]] = 1'b0;
                    void'(lru_list.pop_front());
                end
            end
            KIND_PIN: begin
                if (listed[item.frame_num]) begin
                    for (int i = 0; i < lru_list.size() && !hit; i++) begin
                        if (lru_list[i] == item.frame_num) begin
                            lru_list.delete(i);
                            hit = 1'b1;
                        end
                    end
                    listed[item.frame_num] = 1'b0;
                end
            end
            KIND_UNPIN: begin
                if (!listed[item.frame_num] && lru_list.size() < NUM_FRAMES) begin
                    lru_list.push_back(item.frame_num);
                    listed[item.frame_num] = 1'b1;
                end
            end
            default: begin
            end
        endcase
        res.evictable_count = CNT_W'(lru_list.size());
        return res;
    endfunction

    task automatic report_mismatch(string field, int got, int want);
        $display("%0t mismatch %s: got %0d expected %0d", $time, field, got, want);
        mismatches++;
    endtask

    // receiver stalls
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // predict on input transfers, check on result transfers, count quiet cycles
    always @(posedge aclk) begin
        if (s_valid && s_ready) begin
            predicted_res = predict_replacement(s_data);
            pending_results.push_back(item_has_exp ? item_exp : predicted_res);
        end
        if (m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result, count",
                                int'(m_data.evictable_count), -1);
            end else begin
                oldest_res = pending_results.pop_front();
                results_seen++;
                if (m_data.victim_found !== oldest_res.victim_found)
                    report_mismatch("victim_found", int'(m_data.victim_found),
                                    int'(oldest_res.victim_found));
                if (m_data.victim_frame !== oldest_res.victim_frame)
                    report_mismatch("victim_frame", int'(m_data.victim_frame),
                                    int'(oldest_res.victim_frame));
                if (m_data.evictable_count !== oldest_res.evictable_count)
                    report_mismatch("evictable_count", int'(m_data.evictable_count),
                                    int'(oldest_res.evictable_count));
            end
        end
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    // watchdog on cycles without any transfer
    initial begin
        while (idle_cycles < STALL_LIMIT) @(posedge aclk);
        $display("lru_frame_replacer_tb: FAIL");
        $finish;
    end

    // present one item after a random gap and wait for its transfer
    task automatic send_item(lfr_in_t item, logic has_exp, lfr_out_t exp_res);
        int gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_data       <= item;
        item_has_exp <= has_exp;
        item_exp     <= exp_res;
        do @(posedge aclk); while (!s_ready);
        sent_cnt++;
    endtask

    // sender holds off until every expected result has come back
    task automatic wait_results_drained();
        s_valid <= 1'b0;
        while (results_seen < sent_cnt) @(posedge aclk);
    endtask

    function automatic lfr_in_t random_item();
        lfr_in_t item;
        int      r;
        r = $urandom_range(99);
        if (r < 25)
            item.kind = KIND_VICTIM;
        else if (r < 55)
            item.kind = KIND_PIN;
        else if (r < 95)
            item.kind = KIND_UNPIN;
        else
            item.kind = KIND_NONE;
        // a narrow pool makes pins and duplicate unpins hit listed frames
        if ($urandom_range(1))
            item.frame_num = FID_W'($urandom_range(63));
        else
            item.frame_num = FID_W'($urandom_range(11));
        return item;
    endfunction

    initial begin
        lfr_in_t item;
        lfr_out_t typed;
        int fill_order [NUM_FRAMES];
        int j;
        int tmp;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // directed table, no idling
        for (int r = 0; r < DIR_ROWS; r++) begin
            item.kind             = DIRECTED[r].kind;
            item.frame_num        = DIRECTED[r].frame_num;
            typed.victim_found    = DIRECTED[r].found;
            typed.victim_frame    = DIRECTED[r].frame;
            typed.evictable_count = DIRECTED[r].count;
            send_item(item, DIRECTED[r].has_exp, typed);
        end
        wait_results_drained();

        // random phases: none, sender idle, receiver stall, both
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 47; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 47; end
                default: begin tx_idle_pct = 16; rx_stall_pct = 16; end
            endcase
            // fill the list to every frame in a shuffled order, once per phase pair
            if (ph == 1 || ph == 3) begin
                for (int i = 0; i < NUM_FRAMES; i++) fill_order[i] = i;
                for (int i = NUM_FRAMES - 1; i > 0; i--) begin
                    j = $urandom_range(i);
                    tmp = fill_order[i];
                    fill_order[i] = fill_order[j];
                    fill_order[j] = tmp;
                end
                for (int i = 0; i < NUM_FRAMES; i++) begin
                    item.kind      = KIND_UNPIN;
                    item.frame_num = FID_W'(fill_order[i]);
                    send_item(item, 1'b0, '0);
                end
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_item(random_item(), 1'b0, '0);
            end
            wait_results_drained();
        end

        // tail: let any stray result show up
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("lru_frame_replacer_tb: PASS");
        end else begin
            $display("lru_frame_replacer_tb: FAIL");
        end
        $finish;
    end

endmodule
